// ===== rtl/core/shs_pkg.sv =====
// Shared types, constants and round functions for the SHA-256 stream hasher.
`default_nettype none

package shs_pkg;

    localparam int BLOCK_BYTES     = 64;
    localparam int BLOCK_BITS      = 512;
    localparam int ROUNDS          = 64;
    localparam int PAD_LIMIT       = 56;
    localparam int QUEUE_DEPTH_DEF = 2;
    localparam logic [7:0] PAD_BYTE = 8'h80;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       last;
    } in_beat_t;

    typedef struct packed {
        logic [63:0] digest_bits_255_192;
        logic [63:0] digest_bits_191_128;
        logic [63:0] digest_bits_127_64;
        logic [63:0] digest_bits_63_0;
    } out_beat_t;

    // One block handed from the front to the compression engine.
    typedef struct packed {
        logic [BLOCK_BITS-1:0] block;     // byte 0 in the top bits
        logic                  last_blk;  // closes the message, digest wanted
    } blk_job_t;

    localparam logic [31:0] IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] K_TABLE [ROUNDS] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [31:0] big_sig0(input logic [31:0] x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic logic [31:0] big_sig1(input logic [31:0] x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic logic [31:0] small_sig0(input logic [31:0] x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic logic [31:0] small_sig1(input logic [31:0] x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/shs_front.sv =====
// Byte gatherer: fills blocks, pads and appends the length, issues block jobs.
`default_nettype none

module shs_front (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire shs_pkg::in_beat_t s_data,
    output logic                  push_valid,
    input  wire logic             push_ready,
    output shs_pkg::blk_job_t     push_data
);

    logic [7:0]  buf_reg [shs_pkg::BLOCK_BYTES];
    logic [5:0]  fill_reg, fill_next;
    logic [60:0] cnt_reg, cnt_next;
    logic        pend_valid_reg, pend_valid_next;
    logic        pend_lead_reg, pend_lead_next;
    logic [63:0] pend_len_reg, pend_len_next;

    logic        acc;
    logic [6:0]  fill_sum;
    logic        full;
    logic [60:0] cnt_sum;
    logic [63:0] len_bits;
    logic [7:0]  byte_with [shs_pkg::BLOCK_BYTES];
    logic [shs_pkg::BLOCK_BITS-1:0] full_blk, pad_blk, pend_blk;
    logic        pad_fits;

    assign s_ready  = !pend_valid_reg && push_ready;
    assign acc      = s_valid && s_ready;
    assign fill_sum = {1'b0, fill_reg} + 7'(s_data.has_byte);
    assign full     = fill_sum[6];
    assign cnt_sum  = cnt_reg + 61'(s_data.has_byte);
    assign len_bits = {cnt_sum, 3'b000};
    assign pad_fits = fill_sum <= 7'(shs_pkg::PAD_LIMIT - 1);

    always_comb begin
        full_blk = '0;
        pad_blk  = '0;
        for (int i = 0; i < shs_pkg::BLOCK_BYTES; i++) begin
            byte_with[i] = (s_data.has_byte && fill_reg == 6'(i)) ? s_data.data_byte
                                                                  : buf_reg[i];
            full_blk[511 - 8*i -: 8] = byte_with[i];
            if (7'(i) < fill_sum) begin
                pad_blk[511 - 8*i -: 8] = byte_with[i];
            end else if (7'(i) == fill_sum) begin
                pad_blk[511 - 8*i -: 8] = shs_pkg::PAD_BYTE;
            end
        end
        if (pad_fits) begin
            pad_blk[63:0] = len_bits;
        end
        pend_blk = '0;
        if (pend_lead_reg) begin
            pend_blk[511:504] = shs_pkg::PAD_BYTE;
        end
        pend_blk[63:0] = pend_len_reg;
    end

    // Job selection: a held trailer block goes first, then full or padded blocks.
    always_comb begin
        push_valid = pend_valid_reg || (acc && (full || s_data.last));
        if (pend_valid_reg) begin
            push_data = '{block: pend_blk, last_blk: 1'b1};
        end else if (full) begin
            push_data = '{block: full_blk, last_blk: 1'b0};
        end else begin
            push_data = '{block: pad_blk, last_blk: pad_fits};
        end
    end

    always_comb begin
        fill_next       = fill_reg;
        cnt_next        = cnt_reg;
        pend_valid_next = pend_valid_reg;
        pend_lead_next  = pend_lead_reg;
        pend_len_next   = pend_len_reg;
        if (pend_valid_reg && push_ready) begin
            pend_valid_next = 1'b0;
        end
        if (acc) begin
            if (s_data.last) begin
                fill_next = '0;
                cnt_next  = '0;
                if (full || !pad_fits) begin
                    pend_valid_next = 1'b1;
                    pend_lead_next  = full;
                    pend_len_next   = len_bits;
                end
            end else begin
                fill_next = fill_sum[5:0];
                cnt_next  = cnt_sum;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg       <= '0;
            cnt_reg        <= '0;
            pend_valid_reg <= 1'b0;
        end else begin
            fill_reg       <= fill_next;
            cnt_reg        <= cnt_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pend_lead_reg <= pend_lead_next;
        pend_len_reg  <= pend_len_next;
        if (acc && s_data.has_byte) begin
            buf_reg[fill_reg] <= s_data.data_byte;
        end
    end

    a_pend_after_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_valid_reg |-> (fill_reg == '0 && cnt_reg == '0))
        else $error("trailer pending while a new block is filling");

endmodule

`default_nettype wire

// ===== rtl/core/shs_queue.sv =====
// Short job queue between the byte gatherer and the compression engine.
`default_nettype none

module shs_queue #(
    parameter int DEPTH = shs_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              wr_valid,
    output logic                   wr_ready,
    input  wire shs_pkg::blk_job_t wr_data,
    output logic                   rd_valid,
    input  wire logic              rd_ready,
    output shs_pkg::blk_job_t      rd_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    shs_pkg::blk_job_t mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_wr, do_rd;

    assign wr_ready = cnt_reg != CNT_W'(DEPTH);
    assign rd_valid = cnt_reg != '0;
    assign rd_data  = mem[rd_ptr_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_wr) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (do_rd && !do_wr) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_wr) begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(DEPTH))
        else $error("queue occupancy beyond depth");

endmodule

`default_nettype wire

// ===== rtl/core/shs_back.sv =====
// Compression engine: one SHA-256 round per cycle, chaining state, digest register.
`default_nettype none

module shs_back (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              job_valid,
    output logic                   job_ready,
    input  wire shs_pkg::blk_job_t job_data,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output shs_pkg::out_beat_t     m_data
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_ROUND  = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;

    logic [1:0]  state_reg, state_next;
    logic [5:0]  round_reg, round_next;
    logic        last_reg, last_next;
    logic [31:0] chain_reg [8];
    logic [31:0] chain_next [8];
    logic [31:0] wk_reg [8];    // a..h
    logic [31:0] wk_next [8];
    logic [31:0] w_reg [16];
    logic [31:0] w_next [16];
    logic        m_valid_reg, m_valid_next;
    shs_pkg::out_beat_t m_data_reg, m_data_next;

    logic [31:0] t1, t2, w_new;
    logic [31:0] sum [8];
    logic        out_free;

    assign job_ready = state_reg == ST_IDLE;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;
    assign out_free  = !m_valid_reg || m_ready;

    always_comb begin
        t1 = wk_reg[7] + shs_pkg::big_sig1(wk_reg[4])
           + ((wk_reg[4] & wk_reg[5]) ^ (~wk_reg[4] & wk_reg[6]))
           + shs_pkg::K_TABLE[round_reg] + w_reg[0];
        t2 = shs_pkg::big_sig0(wk_reg[0])
           + ((wk_reg[0] & wk_reg[1]) ^ (wk_reg[0] & wk_reg[2]) ^ (wk_reg[1] & wk_reg[2]));
        w_new = shs_pkg::small_sig1(w_reg[14]) + w_reg[9]
              + shs_pkg::small_sig0(w_reg[1]) + w_reg[0];
        for (int i = 0; i < 8; i++) begin
            sum[i] = chain_reg[i] + wk_reg[i];
        end
    end

    always_comb begin
        state_next   = state_reg;
        round_next   = round_reg;
        last_next    = last_reg;
        chain_next   = chain_reg;
        wk_next      = wk_reg;
        w_next       = w_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE: begin
                if (job_valid) begin
                    wk_next    = chain_reg;
                    last_next  = job_data.last_blk;
                    round_next = '0;
                    for (int j = 0; j < 16; j++) begin
                        w_next[j] = job_data.block[511 - 32*j -: 32];
                    end
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND: begin
                wk_next[0] = t1 + t2;
                wk_next[1] = wk_reg[0];
                wk_next[2] = wk_reg[1];
                wk_next[3] = wk_reg[2];
                wk_next[4] = wk_reg[3] + t1;
                wk_next[5] = wk_reg[4];
                wk_next[6] = wk_reg[5];
                wk_next[7] = wk_reg[6];
                for (int j = 0; j < 15; j++) begin
                    w_next[j] = w_reg[j + 1];
                end
                w_next[15] = w_new;
                round_next = round_reg + 1'b1;
                if (round_reg == 6'(shs_pkg::ROUNDS - 1)) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (!last_reg) begin
                    chain_next = sum;
                    state_next = ST_IDLE;
                end else if (out_free) begin
                    m_data_next  = '{digest_bits_255_192: {sum[0], sum[1]},
                                     digest_bits_191_128: {sum[2], sum[3]},
                                     digest_bits_127_64:  {sum[4], sum[5]},
                                     digest_bits_63_0:    {sum[6], sum[7]}};
                    m_valid_next = 1'b1;
                    chain_next   = shs_pkg::IV;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            round_reg   <= '0;
            last_reg    <= 1'b0;
            chain_reg   <= shs_pkg::IV;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            round_reg   <= round_next;
            last_reg    <= last_next;
            chain_reg   <= chain_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        wk_reg     <= wk_next;
        w_reg      <= w_next;
        m_data_reg <= m_data_next;
    end

    a_round_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ROUND && round_reg == 6'(shs_pkg::ROUNDS - 1))
        |=> state_reg == ST_FINISH)
        else $error("round count did not close the block");

    a_digest_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> ($past(last_reg) && $past(state_reg) == ST_FINISH))
        else $error("digest raised outside a closing block");

endmodule

`default_nettype wire

// ===== rtl/core/sha256_stream_hasher_core.sv =====
// Top level of the streaming SHA-256 hasher: gatherer, job queue, compression engine.
// Throughput: one byte beat per cycle while the queue has room and no trailer waits;
//   a last beat that needs a trailer block holds the input until the trailer is queued;
//   each block holds the engine through its rounds and finish step.
// Digest: raised as the closing block ends; queued blocks or an untaken digest delay it.
// Reset: synchronous, active low; initial hash words restored, counts and queue cleared.
`default_nettype none

module sha256_stream_hasher_core #(
    parameter int QUEUE_DEPTH = shs_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire shs_pkg::in_beat_t s_data,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output shs_pkg::out_beat_t     m_data
);

    // Front to queue
    logic              push_valid, push_ready;
    shs_pkg::blk_job_t push_data;
    // Queue to engine
    logic              job_valid, job_ready;
    shs_pkg::blk_job_t job_data;

    // Gathers bytes; a full block or a padded final block becomes one job.
    // A held trailer block (length, plus the pad byte after a full block) is issued next.
    shs_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    // Decouples byte intake from the round engine so filling overlaps compression.
    shs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (push_valid),
        .wr_ready (push_ready),
        .wr_data  (push_data),
        .rd_valid (job_valid),
        .rd_ready (job_ready),
        .rd_data  (job_data)
    );

    // One round per cycle; digest sits in an output register until taken.
    shs_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .job_valid (job_valid),
        .job_ready (job_ready),
        .job_data  (job_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

`default_nettype wire
